// File: hw/rtl/obb_overlap_test_top_assert.svh
// ----------------------------------------------------------------------------
// obb assertion macros
// shared concurrent assertion forms for the oriented-box overlap block
// ----------------------------------------------------------------------------
`ifndef OBB_OVERLAP_TEST_TOP_ASSERT_SVH
`define OBB_OVERLAP_TEST_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define OBB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("obb assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define OBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("obb assertion failed");

`endif

// File: hw/rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb package
// constants and fixed-point helpers for the oriented-box overlap block
// ----------------------------------------------------------------------------
package obb_pkg;

    localparam int OBB_COORD_WIDTH = 32;
    localparam int HALF_WIDTH      = 31;
    localparam int QUAT_WIDTH      = 16;

    localparam logic signed [15:0] Q_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;

    // round Q3.27 to Q1.14 with saturation
    function automatic logic signed [15:0] rnd13(input logic signed [33:0] v);
        logic signed [33:0] f;
        f = (v + 34'sd4096) >>> 13;
        if (f > 34'sd16384) begin
            return Q_ONE;
        end else if (f < -34'sd16384) begin
            return Q_NEG_ONE;
        end
        return 16'(f);
    endfunction

    // round Q2.28 sum of products to Q1.14 with saturation
    function automatic logic signed [15:0] rnd14(input logic signed [33:0] v);
        logic signed [33:0] f;
        f = (v + 34'sd8192) >>> 14;
        if (f > 34'sd16384) begin
            return Q_ONE;
        end else if (f < -34'sd16384) begin
            return Q_NEG_ONE;
        end
        return 16'(f);
    endfunction

endpackage

// File: hw/rtl/obb_in_if.sv
// ----------------------------------------------------------------------------
// obb input channel
// valid/ready channel carrying one load or test box
// ----------------------------------------------------------------------------
interface obb_in_if #(
    parameter int COORD_WIDTH = obb_pkg::OBB_COORD_WIDTH
);
    logic                                   valid;
    logic                                   ready;
    logic                                   func;
    logic signed [COORD_WIDTH-1:0]          center_x;
    logic signed [COORD_WIDTH-1:0]          center_y;
    logic signed [COORD_WIDTH-1:0]          center_z;
    logic [obb_pkg::HALF_WIDTH-1:0]         half_x;
    logic [obb_pkg::HALF_WIDTH-1:0]         half_y;
    logic [obb_pkg::HALF_WIDTH-1:0]         half_z;
    logic signed [obb_pkg::QUAT_WIDTH-1:0]  quat_w;
    logic signed [obb_pkg::QUAT_WIDTH-1:0]  quat_x;
    logic signed [obb_pkg::QUAT_WIDTH-1:0]  quat_y;
    logic signed [obb_pkg::QUAT_WIDTH-1:0]  quat_z;

    modport source (
        output valid, func, center_x, center_y, center_z, half_x, half_y, half_z,
               quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, func, center_x, center_y, center_z, half_x, half_y, half_z,
               quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

// File: hw/rtl/obb_out_if.sv
// ----------------------------------------------------------------------------
// obb result channel
// valid/ready channel carrying one overlap flag
// ----------------------------------------------------------------------------
interface obb_out_if;
    logic valid;
    logic ready;
    logic overlap;

    modport source (output valid, overlap, input ready);
    modport sink (input valid, overlap, output ready);
endinterface

// File: hw/rtl/obb_overlap_test_top.sv
// ----------------------------------------------------------------------------
// obb overlap test top
// oriented-box separating axis test against a held reference box
// ----------------------------------------------------------------------------
// Takes one item per cycle and returns each test result, in order, from the end of
// the pipeline; a load transfer updates the reference and gives no result. The
// rate is set by the seven-stage pipeline (quaternion products, matrix and
// offset, rotation products, relative rotation and offset, projection
// products, axis compares), which advances as a whole and halts only while
// a finished result waits to be taken. A test right after a load sees it.
module obb_overlap_test_top #(
    parameter int COORD_WIDTH = obb_pkg::OBB_COORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obb_in_if.sink      i_item,
    obb_out_if.source   o_result
);

    localparam int HW  = obb_pkg::HALF_WIDTH;
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = DW + 16;
    localparam int TW  = PW - 12;
    localparam int RW  = TW + 16;
    localparam int AW  = 15;
    localparam int HPW = HW + AW;
    localparam int SW  = (TW + 19 > 50) ? TW + 19 : 50;

    logic       en;
    logic [7:1] r_v;

    logic                          r1_func;
    logic signed [COORD_WIDTH-1:0] r1_c [3];
    logic [HW-1:0]                 r1_h [3];
    logic signed [15:0]            r1_q [4];

    logic                          r2_func;
    logic signed [COORD_WIDTH-1:0] r2_c [3];
    logic [HW-1:0]                 r2_h [3];
    logic signed [31:0]            r2_p [9];

    logic signed [15:0]            n_b [9];
    logic signed [DW-1:0]          n_d [3];

    logic signed [COORD_WIDTH-1:0] r_ref_c [3];
    logic [HW-1:0]                 r_ref_h [3];
    logic signed [15:0]            r_ref_a [9];

    logic signed [15:0]            r3_b [9];
    logic signed [15:0]            r3_a [9];
    logic signed [DW-1:0]          r3_d [3];
    logic [HW-1:0]                 r3_hb [3];
    logic [HW-1:0]                 r3_ha [3];

    logic signed [31:0]            r4_pr [3][3][3];
    logic signed [PW-1:0]          r4_pt [3][3];
    logic [HW-1:0]                 r4_hb [3];
    logic [HW-1:0]                 r4_ha [3];

    logic signed [15:0]            n_r [3][3];
    logic signed [TW-1:0]          n_t [3];

    logic signed [15:0]            r5_r [3][3];
    logic [AW-1:0]                 r5_ar [3][3];
    logic signed [TW-1:0]          r5_t [3];
    logic [HW-1:0]                 r5_hb [3];
    logic [HW-1:0]                 r5_ha [3];

    logic signed [SW-1:0]          n_at [3];

    logic signed [RW-1:0]          r6_pt [3][3][3];
    logic [HPW-1:0]                r6_ph [3][3][3];
    logic [HPW-1:0]                r6_pb [3][3][3];
    logic signed [SW-1:0]          r6_at [3];
    logic [HW-1:0]                 r6_hb [3];
    logic [HW-1:0]                 r6_ha [3];

    logic                          n_ovl;
    logic                          r_ovl;

    assign en             = !r_v[7] || o_result.ready;
    assign i_item.ready   = en;
    assign o_result.valid = r_v[7];
    assign o_result.overlap = r_ovl;

    // valid chain, loads leave after stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v[1] <= i_item.valid;
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2] && r2_func;
            r_v[4] <= r_v[3];
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    // reference box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_ref_c[k] <= '0;
                r_ref_h[k] <= '0;
            end
            for (int k = 0; k < 9; k++) begin
                r_ref_a[k] <= (k % 4 == 0) ? obb_pkg::Q_ONE : 16'sd0;
            end
        end else if (en && r_v[2] && !r2_func) begin
            r_ref_c <= r2_c;
            r_ref_h <= r2_h;
            r_ref_a <= n_b;
        end
    end

    // stage 2 combinational: matrix and offset
    always_comb begin
        logic signed [33:0] one;
        one    = 34'sd134217728;
        n_b[0] = obb_pkg::rnd13(one - (34'(r2_p[1]) + 34'(r2_p[2])));
        n_b[1] = obb_pkg::rnd13(34'(r2_p[3]) - 34'(r2_p[8]));
        n_b[2] = obb_pkg::rnd13(34'(r2_p[4]) + 34'(r2_p[7]));
        n_b[3] = obb_pkg::rnd13(34'(r2_p[3]) + 34'(r2_p[8]));
        n_b[4] = obb_pkg::rnd13(one - (34'(r2_p[0]) + 34'(r2_p[2])));
        n_b[5] = obb_pkg::rnd13(34'(r2_p[5]) - 34'(r2_p[6]));
        n_b[6] = obb_pkg::rnd13(34'(r2_p[4]) - 34'(r2_p[7]));
        n_b[7] = obb_pkg::rnd13(34'(r2_p[5]) + 34'(r2_p[6]));
        n_b[8] = obb_pkg::rnd13(one - (34'(r2_p[0]) + 34'(r2_p[1])));
        for (int k = 0; k < 3; k++) begin
            n_d[k] = DW'(r2_c[k]) - DW'(r_ref_c[k]);
        end
    end

    // stage 4 combinational: relative rotation and rotated offset
    always_comb begin
        logic signed [PW-1:0] rnd;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_r[i][j] = obb_pkg::rnd14(34'(r4_pr[i][j][0]) + 34'(r4_pr[i][j][1])
                                           + 34'(r4_pr[i][j][2]));
            end
            n_t[i] = '0;
            for (int k = 0; k < 3; k++) begin
                rnd    = (r4_pt[i][k] + PW'(8192)) >>> 14;
                n_t[i] = n_t[i] + TW'(rnd);
            end
        end
    end

    // stage 5 combinational: clamped offset magnitudes
    always_comb begin
        logic signed [SW-1:0] v;
        for (int i = 0; i < 3; i++) begin
            v = SW'(r5_t[i]);
            if (v < 0) begin
                v = -v;
            end
            if (v > (SW'(1) <<< 34)) begin
                v = SW'(1) <<< 34;
            end
            n_at[i] = v;
        end
    end

    // stage 6 combinational: the fifteen axis tests
    always_comb begin
        logic signed [SW-1:0] lhs;
        logic signed [SW-1:0] rhs;
        int                   i1, i2, j1, j2;
        n_ovl = 1'b1;
        for (int i = 0; i < 3; i++) begin
            rhs = SW'(r6_ha[i]) <<< 14;
            for (int j = 0; j < 3; j++) begin
                rhs = rhs + SW'(r6_pb[j][i][j]);
            end
            if ((r6_at[i] <<< 14) > rhs) begin
                n_ovl = 1'b0;
            end
        end
        for (int j = 0; j < 3; j++) begin
            lhs = '0;
            rhs = SW'(r6_hb[j]) <<< 14;
            for (int i = 0; i < 3; i++) begin
                lhs = lhs + SW'(r6_pt[i][i][j]);
                rhs = rhs + SW'(r6_ph[i][i][j]);
            end
            if (lhs < 0) begin
                lhs = -lhs;
            end
            if (lhs > rhs) begin
                n_ovl = 1'b0;
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                i1  = (i + 1) % 3;
                i2  = (i + 2) % 3;
                j1  = (j + 1) % 3;
                j2  = (j + 2) % 3;
                lhs = SW'(r6_pt[i2][i1][j]) - SW'(r6_pt[i1][i2][j]);
                rhs = SW'(r6_ph[i1][i2][j]) + SW'(r6_ph[i2][i1][j])
                    + SW'(r6_pb[j1][i][j2]) + SW'(r6_pb[j2][i][j1]);
                if (lhs < 0) begin
                    lhs = -lhs;
                end
                if (lhs > rhs) begin
                    n_ovl = 1'b0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_func <= i_item.func;
            r1_c[0] <= i_item.center_x;
            r1_c[1] <= i_item.center_y;
            r1_c[2] <= i_item.center_z;
            r1_h[0] <= i_item.half_x;
            r1_h[1] <= i_item.half_y;
            r1_h[2] <= i_item.half_z;
            r1_q[0] <= i_item.quat_w;
            r1_q[1] <= i_item.quat_x;
            r1_q[2] <= i_item.quat_y;
            r1_q[3] <= i_item.quat_z;

            r2_func <= r1_func;
            r2_c    <= r1_c;
            r2_h    <= r1_h;
            r2_p[0] <= 32'(r1_q[1]) * 32'(r1_q[1]);
            r2_p[1] <= 32'(r1_q[2]) * 32'(r1_q[2]);
            r2_p[2] <= 32'(r1_q[3]) * 32'(r1_q[3]);
            r2_p[3] <= 32'(r1_q[1]) * 32'(r1_q[2]);
            r2_p[4] <= 32'(r1_q[1]) * 32'(r1_q[3]);
            r2_p[5] <= 32'(r1_q[2]) * 32'(r1_q[3]);
            r2_p[6] <= 32'(r1_q[0]) * 32'(r1_q[1]);
            r2_p[7] <= 32'(r1_q[0]) * 32'(r1_q[2]);
            r2_p[8] <= 32'(r1_q[0]) * 32'(r1_q[3]);

            r3_b  <= n_b;
            r3_a  <= r_ref_a;
            r3_d  <= n_d;
            r3_hb <= r2_h;
            r3_ha <= r_ref_h;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_pr[i][j][0] <= 32'(r3_a[i]) * 32'(r3_b[j]);
                    r4_pr[i][j][1] <= 32'(r3_a[3 + i]) * 32'(r3_b[3 + j]);
                    r4_pr[i][j][2] <= 32'(r3_a[6 + i]) * 32'(r3_b[6 + j]);
                    r4_pt[i][j]    <= PW'(r3_a[j * 3 + i]) * PW'(r3_d[j]);
                end
            end
            r4_hb <= r3_hb;
            r4_ha <= r3_ha;

            r5_r  <= n_r;
            r5_t  <= n_t;
            r5_hb <= r4_hb;
            r5_ha <= r4_ha;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r5_ar[i][j] <= (n_r[i][j] < 0) ? AW'(-n_r[i][j]) : AW'(n_r[i][j]);
                end
            end

            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    for (int j = 0; j < 3; j++) begin
                        r6_pt[a][b][j] <= RW'(r5_t[a]) * RW'(r5_r[b][j]);
                        r6_ph[a][b][j] <= HPW'(r5_ha[a]) * HPW'(r5_ar[b][j]);
                        r6_pb[a][b][j] <= HPW'(r5_hb[a]) * HPW'(r5_ar[b][j]);
                    end
                end
            end
            r6_at <= n_at;
            r6_hb <= r5_hb;
            r6_ha <= r5_ha;

            r_ovl <= n_ovl;
        end
    end

    `include "obb_overlap_test_top_assert.svh"

    `OBB_ASSERT_NEXT(a_accept_enters, i_item.valid && i_item.ready, r_v[1])
    `OBB_ASSERT_NEXT(a_stall_freezes, !en, r_v == $past(r_v))
    `OBB_ASSERT_NEXT(a_load_no_result, en && r_v[2] && !r2_func, !r_v[3])
    `OBB_ASSERT_NEXT(a_load_writes_ref, en && r_v[2] && !r2_func,
                     r_ref_h[0] == $past(r2_h[0]) && r_ref_c[2] == $past(r2_c[2]))

endmodule

// File: tb/sv/obb_overlap_checker.sv
// ----------------------------------------------------------------------------
// obb overlap checker
// watches both channels, keeps its own copy of the reference box, predicts
// the overlap flag of every test transfer and compares it in order
// ----------------------------------------------------------------------------
module obb_overlap_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    obb_in_if     i_item,
    obb_out_if    i_result,
    output int    o_errors,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNIT = 16384;

    longint box_center[3];
    longint box_half[3];
    longint box_rot[9];
    bit     flag_queue[$];
    int     errors;

    assign o_errors  = errors;
    assign o_pending = flag_queue.size();

    function automatic longint clip_unit(input longint v);
        if (v > UNIT) return UNIT;
        if (v < -UNIT) return -UNIT;
        return v;
    endfunction

    function automatic longint abs64(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint quat_entry(input longint v);
        return clip_unit((v + 4096) >>> 13);
    endfunction

    function automatic void quat_rotation(input longint w, input longint x,
                                          input longint y, input longint z,
                                          output longint m[9]);
        longint one;
        one = longint'(1) << 27;
        m[0] = quat_entry(one - (y * y + z * z));
        m[1] = quat_entry(x * y - w * z);
        m[2] = quat_entry(x * z + w * y);
        m[3] = quat_entry(x * y + w * z);
        m[4] = quat_entry(one - (x * x + z * z));
        m[5] = quat_entry(y * z - w * x);
        m[6] = quat_entry(x * z - w * y);
        m[7] = quat_entry(y * z + w * x);
        m[8] = quat_entry(one - (x * x + y * y));
    endfunction

    function automatic bit boxes_overlap(input longint c[3], input longint hb[3],
                                         input longint bq[9]);
        longint r[3][3];
        longint ar[3][3];
        longint t[3];
        longint d[3];
        longint s, lhs, rhs, at;
        int i1, i2, j1, j2;
        for (int k = 0; k < 3; k++) d[k] = c[k] - box_center[k];
        for (int i = 0; i < 3; i++) begin
            t[i] = 0;
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s += box_rot[k*3+i] * bq[k*3+j];
                r[i][j]  = clip_unit((s + 8192) >>> 14);
                ar[i][j] = abs64(r[i][j]);
            end
            for (int k = 0; k < 3; k++) t[i] += (box_rot[k*3+i] * d[k] + 8192) >>> 14;
        end
        for (int i = 0; i < 3; i++) begin
            at  = abs64(t[i]);
            rhs = box_half[i] << 14;
            if (at > (longint'(1) << 34)) at = longint'(1) << 34;
            for (int j = 0; j < 3; j++) rhs += hb[j] * ar[i][j];
            if ((at << 14) > rhs) return 1'b0;
        end
        for (int j = 0; j < 3; j++) begin
            lhs = 0;
            rhs = hb[j] << 14;
            for (int i = 0; i < 3; i++) begin
                lhs += t[i] * r[i][j];
                rhs += box_half[i] * ar[i][j];
            end
            if (abs64(lhs) > rhs) return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            i1 = (i + 1) % 3;
            i2 = (i + 2) % 3;
            for (int j = 0; j < 3; j++) begin
                j1  = (j + 1) % 3;
                j2  = (j + 2) % 3;
                lhs = t[i2] * r[i1][j] - t[i1] * r[i2][j];
                rhs = box_half[i1] * ar[i2][j] + box_half[i2] * ar[i1][j]
                    + hb[j1] * ar[i][j2] + hb[j2] * ar[i][j1];
                if (abs64(lhs) > rhs) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        longint c[3];
        longint hb[3];
        longint bq[9];
        bit     want;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                box_center[k] = 0;
                box_half[k]   = 0;
            end
            for (int k = 0; k < 9; k++) box_rot[k] = (k % 4 == 0) ? UNIT : 0;
            flag_queue.delete();
            errors = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                if (flag_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, overlap=%0b",
                             $time, i_result.overlap);
                end else begin
                    want = flag_queue.pop_front();
                    if (i_result.overlap !== want) begin
                        errors++;
                        $display("%0t: overlap expected %0b actual %0b",
                                 $time, want, i_result.overlap);
                    end
                end
            end
            if (i_item.valid && i_item.ready) begin
                c[0]  = longint'(i_item.center_x);
                c[1]  = longint'(i_item.center_y);
                c[2]  = longint'(i_item.center_z);
                hb[0] = longint'({1'b0, i_item.half_x});
                hb[1] = longint'({1'b0, i_item.half_y});
                hb[2] = longint'({1'b0, i_item.half_z});
                quat_rotation(longint'(i_item.quat_w), longint'(i_item.quat_x),
                              longint'(i_item.quat_y), longint'(i_item.quat_z), bq);
                if (i_item.func) begin
                    flag_queue.push_back(boxes_overlap(c, hb, bq));
                end else begin
                    box_center = c;
                    box_half   = hb;
                    box_rot    = bq;
                end
            end
        end
    end
endmodule

// File: tb/sv/obb_overlap_test_top_tb.sv
// ----------------------------------------------------------------------------
// obb overlap test testbench
// directed edge cases then random load and test transfers with random
// gaps and stalls on both channels; the checker predicts every flag
// ----------------------------------------------------------------------------
module obb_overlap_test_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;
    localparam int   ONE_FX    = 65536;
    localparam int   STALL_MAX = 5000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   quiet;
    bit   idle_on;
    int   ref_cx, ref_cy, ref_cz;

    obb_in_if  in_ch ();
    obb_out_if out_ch ();

    obb_overlap_test_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    obb_overlap_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (in_ch),
        .i_result  (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ch.ready = idle_on ? ($urandom_range(99) >= 35) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_box(input logic f, input int cx, input int cy, input int cz,
                            input int hx, input int hy, input int hz,
                            input int qw, input int qx, input int qy, input int qz);
        while (idle_on && $urandom_range(99) < 35) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.func     = f;
        in_ch.center_x = cx;
        in_ch.center_y = cy;
        in_ch.center_z = cz;
        in_ch.half_x   = hx[30:0];
        in_ch.half_y   = hy[30:0];
        in_ch.half_z   = hz[30:0];
        in_ch.quat_w   = qw[15:0];
        in_ch.quat_x   = qx[15:0];
        in_ch.quat_y   = qy[15:0];
        in_ch.quat_z   = qz[15:0];
        in_ch.valid    = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (f == FUNC_LOAD) begin
            ref_cx = cx;
            ref_cy = cy;
            ref_cz = cz;
        end
    endtask

    task automatic rand_quat(output int q[4]);
        real v[4];
        real n;
        n = 0.0;
        for (int k = 0; k < 4; k++) begin
            v[k] = real'($urandom_range(2000)) - 1000.0;
            n += v[k] * v[k];
        end
        if (n < 1.0) begin
            q = '{16384, 0, 0, 0};
        end else begin
            n = $sqrt(n);
            for (int k = 0; k < 4; k++) q[k] = $rtoi(v[k] / n * 16384.0);
        end
    endtask

    function automatic int near(input int base, input int span);
        return base + $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic random_box(input logic f, input bit noisy);
        int q[4];
        int h[3];
        rand_quat(q);
        if ($urandom_range(99) < 5) begin
            for (int k = 0; k < 4; k++) q[k] = int'($signed(16'($urandom)));
        end
        for (int k = 0; k < 3; k++) begin
            h[k] = ($urandom_range(99) < 5) ? 0 : $urandom_range(20 * ONE_FX);
        end
        if (noisy) begin
            send_box(f, $urandom, $urandom, $urandom,
                     $urandom & 32'h7fffffff, $urandom & 32'h7fffffff,
                     $urandom & 32'h7fffffff, $urandom, $urandom, $urandom, $urandom);
        end else if (f == FUNC_LOAD) begin
            send_box(f, near(0, 100 * ONE_FX), near(0, 100 * ONE_FX),
                     near(0, 100 * ONE_FX), h[0], h[1], h[2], q[0], q[1], q[2], q[3]);
        end else begin
            send_box(f, near(ref_cx, 50 * ONE_FX), near(ref_cy, 50 * ONE_FX),
                     near(ref_cz, 50 * ONE_FX), h[0], h[1], h[2], q[0], q[1], q[2], q[3]);
        end
    endtask

    initial begin
        int pick;
        i_rst_n      = 1'b0;
        idle_on      = 1'b1;
        ref_cx       = 0;
        ref_cy       = 0;
        ref_cz       = 0;
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_LOAD;
        in_ch.center_x = '0;
        in_ch.center_y = '0;
        in_ch.center_z = '0;
        in_ch.half_x = '0;
        in_ch.half_y = '0;
        in_ch.half_z = '0;
        in_ch.quat_w = '0;
        in_ch.quat_x = '0;
        in_ch.quat_y = '0;
        in_ch.quat_z = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // test against the reset box, then load a box of half extent one
        send_box(FUNC_TEST, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_TEST, ONE_FX, 0, 0, ONE_FX - 1, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_TEST, ONE_FX, 0, 0, ONE_FX, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_LOAD, 0, 0, 0, ONE_FX, ONE_FX, ONE_FX, 16384, 0, 0, 0);
        // touching faces, then one lsb apart
        send_box(FUNC_TEST, 2 * ONE_FX, 0, 0, ONE_FX, ONE_FX, ONE_FX, 16384, 0, 0, 0);
        send_box(FUNC_TEST, 2 * ONE_FX + 1, 0, 0, ONE_FX, ONE_FX, ONE_FX, 16384, 0, 0, 0);
        send_box(FUNC_TEST, 0, -2 * ONE_FX - 1, 0, ONE_FX, ONE_FX, ONE_FX, 16384, 0, 0, 0);
        // rotated about z by 45 and by 90 degrees
        send_box(FUNC_TEST, 2 * ONE_FX, 2 * ONE_FX, 0, ONE_FX, ONE_FX, ONE_FX,
                 15137, 0, 0, 6270);
        send_box(FUNC_TEST, 12 * ONE_FX / 5, 0, 0, ONE_FX, ONE_FX, ONE_FX, 11585, 0, 0, 11585);
        // huge offsets and extreme extents
        send_box(FUNC_TEST, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 0, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_TEST, 32'h80000000, 0, 0, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff, 0, 16384, 0, 0);
        // non-unit quaternions saturate
        send_box(FUNC_TEST, 0, 3 * ONE_FX, 0, ONE_FX, ONE_FX, ONE_FX, 32767, 32767, 32767, 32767);
        send_box(FUNC_TEST, 0, 0, 3 * ONE_FX, ONE_FX, ONE_FX, ONE_FX,
                 -32768, -32768, -32768, -32768);
        send_box(FUNC_TEST, ONE_FX, ONE_FX, ONE_FX, 0, 0, 0, 0, 0, 0, 0);
        send_box(FUNC_LOAD, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 0, 32'h7fffffff,
                 -16384, 16384, -16384, 16384);
        send_box(FUNC_TEST, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 0,
                 0, 0, 16384, 0);
        send_box(FUNC_TEST, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 16384, 0);
        send_box(FUNC_TEST, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_box(FUNC_TEST, 1, 0, 0, 0, 0, 0, 16384, 0, 0, 0);

        for (int n = 0; n < 1850; n++) begin
            idle_on = !(n >= 600 && n < 900);
            if (n == 1000) begin
                in_ch.valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 6) random_box(FUNC_LOAD, 1'b0);
            else if (pick < 10) random_box(1'($urandom_range(1)), 1'b1);
            else random_box(FUNC_TEST, 1'b0);
        end
        in_ch.valid = 1'b0;
        idle_on = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: obb_overlap_test_top.f
+incdir+hw/rtl
hw/rtl/obb_pkg.sv
hw/rtl/obb_in_if.sv
hw/rtl/obb_out_if.sv
hw/rtl/obb_overlap_test_top.sv
tb/sv/obb_overlap_checker.sv
tb/sv/obb_overlap_test_top_tb.sv
